// ===== design/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, widths and helpers for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int DATA_W    = 32;                    // Q16.16 component
    localparam int FRAC_BITS = 16;                    // fraction bits
    localparam int PROD_W    = 2 * DATA_W;            // full product
    localparam int MSUM_N    = 4;                     // terms per product sum
    localparam int SUM_W     = PROD_W + $clog2(MSUM_N);
    localparam int SIMP_W    = DATA_W + 1;            // add / sub / negate
    localparam int NCOMP     = 4;                     // x, y, z, w
    localparam int STAGES    = 6;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_NEG   = 3'd3,
        FN_CONJ  = 3'd4,
        FN_SCALE = 3'd5,
        FN_ROT   = 3'd6
    } func_t;

    typedef struct packed {
        logic mul;      // load product registers
        logic add;      // load sum register
    } msum_en_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } sat_t;

    // floor(v / 2^FRAC_BITS)
    function automatic logic signed [SUM_W-1:0] shr_fn(input logic signed [SUM_W-1:0] v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic sat_t sat_fn(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > SAT_HI) begin
            r.val  = SAT_HI[DATA_W-1:0];
            r.clip = 1'b1;
        end
        else if (v < SAT_LO) begin
            r.val  = SAT_LO[DATA_W-1:0];
            r.clip = 1'b1;
        end
        else begin
            r.val  = v[DATA_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== design/qau_msum.sv =====
// ----------------------------------------------------------------------------
// qau_msum
// Four signed products, then their signed sum at full precision (two stages).
// ----------------------------------------------------------------------------
module qau_msum import qau_pkg::*; (
    input  logic                     clk,
    input  msum_en_t                 en,
    input  logic signed [DATA_W-1:0] op_a [MSUM_N],
    input  logic signed [DATA_W-1:0] op_b [MSUM_N],
    input  logic [MSUM_N-1:0]        neg,
    output logic signed [SUM_W-1:0]  sum
);

    logic signed [PROD_W-1:0] prod_reg [MSUM_N];
    logic [MSUM_N-1:0]        neg_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            for (int k = 0; k < MSUM_N; k++)
            begin
                prod_reg[k] <= PROD_W'(op_a[k]) * PROD_W'(op_b[k]);
            end
            neg_reg <= neg;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] term;
        sum_next = '0;
        for (int k = 0; k < MSUM_N; k++)
        begin
            term = SUM_W'(prod_reg[k]);
            if (neg_reg[k])
                sum_next = sum_next - term;
            else
                sum_next = sum_next + term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.add)
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ===== design/quaternion_arith_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Q16.16 quaternion add, sub, Hamilton product, negate, conjugate, scale and
// vector rotation, with per-component saturation and a clip flag.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  cmd     | cmd_valid / cmd_ready | func, a_x..a_w, b_x..b_w, scale
//  rsp     | rsp_valid / rsp_ready | r_x, r_y, r_z, r_w, saturated
//
//  Six register stages, one beat per cycle sustained while rsp is not stalled.
//  The rotate path sets the depth: two chained product/sum/saturate passes.
//  Reset clears the stage valid bits only; data registers are not reset.
//  A stall on rsp holds the full stages; an empty stage still loads, so
//  bubbles squeeze out and cmd_ready stays high while any stage is free.
// ----------------------------------------------------------------------------
module quaternion_arith_unit import qau_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               func,
    input  logic signed [DATA_W-1:0] a_x,
    input  logic signed [DATA_W-1:0] a_y,
    input  logic signed [DATA_W-1:0] a_z,
    input  logic signed [DATA_W-1:0] a_w,
    input  logic signed [DATA_W-1:0] b_x,
    input  logic signed [DATA_W-1:0] b_y,
    input  logic signed [DATA_W-1:0] b_z,
    input  logic signed [DATA_W-1:0] b_w,
    input  logic signed [DATA_W-1:0] scale,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [DATA_W-1:0] r_x,
    output logic signed [DATA_W-1:0] r_y,
    output logic signed [DATA_W-1:0] r_z,
    output logic signed [DATA_W-1:0] r_w,
    output logic                     saturated
);

    // ---- stage valids and load enables ----
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] en;

    // en[k]: stage k may load this cycle (empty or its content moves on)
    always_comb
    begin
        en[STAGES] = !vld_reg[STAGES] || rsp_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign cmd_ready = en[1];
    assign rsp_valid = vld_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
                vld_reg[1] <= cmd_valid;
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---- stage 1 inputs ----
    func_t                    fn_in;
    logic signed [DATA_W-1:0] a_in [NCOMP];
    logic signed [DATA_W-1:0] b_in [NCOMP];
    logic signed [DATA_W-1:0] bw_eff;
    logic signed [SIMP_W-1:0] simp_next [NCOMP];

    assign fn_in   = func_t'(func);
    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign a_in[3] = a_w;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;
    assign b_in[3] = b_w;

    // rotate treats B as a pure vector
    assign bw_eff = (fn_in == FN_ROT) ? '0 : b_w;

    // add / sub / negate / conjugate need no multiplier
    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            case (fn_in)
                FN_ADD:  simp_next[i] = SIMP_W'(a_in[i]) + SIMP_W'(b_in[i]);
                FN_SUB:  simp_next[i] = SIMP_W'(a_in[i]) - SIMP_W'(b_in[i]);
                FN_NEG:  simp_next[i] = -SIMP_W'(a_in[i]);
                FN_CONJ: simp_next[i] = (i == NCOMP - 1) ? SIMP_W'(a_in[i])
                                                         : -SIMP_W'(a_in[i]);
                default: simp_next[i] = '0;
            endcase
        end
    end

    // first product A*B (x,y,z,w); scale reuses slot 0 of each component
    logic signed [DATA_W-1:0] h1_a   [NCOMP][MSUM_N];
    logic signed [DATA_W-1:0] h1_b   [NCOMP][MSUM_N];
    logic [MSUM_N-1:0]        h1_neg [NCOMP];

    always_comb
    begin
        // x = aw*bx + ax*bw + ay*bz - az*by
        h1_a[0][0] = a_w; h1_b[0][0] = b_x;
        h1_a[0][1] = a_x; h1_b[0][1] = bw_eff;
        h1_a[0][2] = a_y; h1_b[0][2] = b_z;
        h1_a[0][3] = a_z; h1_b[0][3] = b_y;
        // y = aw*by + ay*bw + az*bx - ax*bz
        h1_a[1][0] = a_w; h1_b[1][0] = b_y;
        h1_a[1][1] = a_y; h1_b[1][1] = bw_eff;
        h1_a[1][2] = a_z; h1_b[1][2] = b_x;
        h1_a[1][3] = a_x; h1_b[1][3] = b_z;
        // z = aw*bz + az*bw + ax*by - ay*bx
        h1_a[2][0] = a_w; h1_b[2][0] = b_z;
        h1_a[2][1] = a_z; h1_b[2][1] = bw_eff;
        h1_a[2][2] = a_x; h1_b[2][2] = b_y;
        h1_a[2][3] = a_y; h1_b[2][3] = b_x;
        // w = aw*bw - ax*bx - ay*by - az*bz
        h1_a[3][0] = a_w; h1_b[3][0] = bw_eff;
        h1_a[3][1] = a_x; h1_b[3][1] = b_x;
        h1_a[3][2] = a_y; h1_b[3][2] = b_y;
        h1_a[3][3] = a_z; h1_b[3][3] = b_z;

        h1_neg[0] = 4'b1000;
        h1_neg[1] = 4'b1000;
        h1_neg[2] = 4'b1000;
        h1_neg[3] = 4'b1110;

        if (fn_in == FN_SCALE)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                h1_a[i][0] = a_in[i];
                h1_b[i][0] = scale;
                for (int k = 1; k < MSUM_N; k++)
                begin
                    h1_b[i][k] = '0;
                end
                h1_neg[i] = '0;
            end
        end
    end

    logic signed [SUM_W-1:0] sum1 [NCOMP];

    for (genvar i = 0; i < NCOMP; i++)
    begin : g_prod1
        qau_msum u_msum (
            .clk  (clk),
            .en   ('{mul: en[1], add: en[2]}),
            .op_a (h1_a[i]),
            .op_b (h1_b[i]),
            .neg  (h1_neg[i]),
            .sum  (sum1[i])
        );
    end

    // ---- sideband through stages 1..2 ----
    func_t                    fn1_reg, fn2_reg;
    logic signed [DATA_W-1:0] a1_reg   [NCOMP];
    logic signed [DATA_W-1:0] a2_reg   [NCOMP];
    logic signed [SIMP_W-1:0] simp1_reg [NCOMP];
    logic signed [SIMP_W-1:0] simp2_reg [NCOMP];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            fn1_reg   <= fn_in;
            a1_reg    <= a_in;
            simp1_reg <= simp_next;
        end
        if (en[2])
        begin
            fn2_reg   <= fn1_reg;
            a2_reg    <= a1_reg;
            simp2_reg <= simp1_reg;
        end
    end

    // ---- stage 3: shift, saturate, pick product or direct result ----
    logic                     use_prod;
    sat_t                     sat3 [NCOMP];
    logic                     clip3_next;
    func_t                    fn3_reg;
    logic signed [DATA_W-1:0] a3_reg   [NCOMP];
    logic signed [DATA_W-1:0] res3_reg [NCOMP];
    logic                     clip3_reg;

    assign use_prod = (fn2_reg == FN_MUL) || (fn2_reg == FN_SCALE) || (fn2_reg == FN_ROT);

    always_comb
    begin
        clip3_next = 1'b0;
        for (int i = 0; i < NCOMP; i++)
        begin
            if (use_prod)
                sat3[i] = sat_fn(shr_fn(sum1[i]));
            else
                sat3[i] = sat_fn(SUM_W'(simp2_reg[i]));
            clip3_next = clip3_next | sat3[i].clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            fn3_reg   <= fn2_reg;
            a3_reg    <= a2_reg;
            clip3_reg <= clip3_next;
            for (int i = 0; i < NCOMP; i++)
            begin
                res3_reg[i] <= sat3[i].val;
            end
        end
    end

    // ---- stages 4..5: second product t*conj(A), x,y,z only ----
    // conj(A) signs folded into the term signs so operands stay 32 bits
    localparam int NVEC = NCOMP - 1;

    logic signed [DATA_W-1:0] h2_a [NVEC][MSUM_N];
    logic signed [DATA_W-1:0] h2_b [NVEC][MSUM_N];
    logic signed [SUM_W-1:0]  sum2 [NVEC];

    always_comb
    begin
        // x = tx*aw - tw*ax - ty*az + tz*ay
        h2_a[0][0] = res3_reg[0]; h2_b[0][0] = a3_reg[3];
        h2_a[0][1] = res3_reg[3]; h2_b[0][1] = a3_reg[0];
        h2_a[0][2] = res3_reg[1]; h2_b[0][2] = a3_reg[2];
        h2_a[0][3] = res3_reg[2]; h2_b[0][3] = a3_reg[1];
        // y = ty*aw - tw*ay - tz*ax + tx*az
        h2_a[1][0] = res3_reg[1]; h2_b[1][0] = a3_reg[3];
        h2_a[1][1] = res3_reg[3]; h2_b[1][1] = a3_reg[1];
        h2_a[1][2] = res3_reg[2]; h2_b[1][2] = a3_reg[0];
        h2_a[1][3] = res3_reg[0]; h2_b[1][3] = a3_reg[2];
        // z = tz*aw - tw*az - tx*ay + ty*ax
        h2_a[2][0] = res3_reg[2]; h2_b[2][0] = a3_reg[3];
        h2_a[2][1] = res3_reg[3]; h2_b[2][1] = a3_reg[2];
        h2_a[2][2] = res3_reg[0]; h2_b[2][2] = a3_reg[1];
        h2_a[2][3] = res3_reg[1]; h2_b[2][3] = a3_reg[0];
    end

    for (genvar i = 0; i < NVEC; i++)
    begin : g_prod2
        qau_msum u_msum (
            .clk  (clk),
            .en   ('{mul: en[4], add: en[5]}),
            .op_a (h2_a[i]),
            .op_b (h2_b[i]),
            .neg  (4'b0110),
            .sum  (sum2[i])
        );
    end

    func_t                    fn4_reg, fn5_reg;
    logic signed [DATA_W-1:0] res4_reg [NCOMP];
    logic signed [DATA_W-1:0] res5_reg [NCOMP];
    logic                     clip4_reg, clip5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            fn4_reg   <= fn3_reg;
            res4_reg  <= res3_reg;
            clip4_reg <= clip3_reg;
        end
        if (en[5])
        begin
            fn5_reg   <= fn4_reg;
            res5_reg  <= res4_reg;
            clip5_reg <= clip4_reg;
        end
    end

    // ---- stage 6: output register ----
    sat_t                     sat6 [NVEC];
    logic signed [DATA_W-1:0] res6_next [NCOMP];
    logic                     clip6_next;
    logic signed [DATA_W-1:0] res6_reg [NCOMP];
    logic                     clip6_reg;

    always_comb
    begin
        res6_next  = res5_reg;
        clip6_next = clip5_reg;
        for (int i = 0; i < NVEC; i++)
        begin
            sat6[i] = sat_fn(shr_fn(sum2[i]));
        end
        if (fn5_reg == FN_ROT)
        begin
            // w of the second product is dropped and never flags a clip
            for (int i = 0; i < NVEC; i++)
            begin
                res6_next[i] = sat6[i].val;
                clip6_next   = clip6_next | sat6[i].clip;
            end
            res6_next[NCOMP-1] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            res6_reg  <= res6_next;
            clip6_reg <= clip6_next;
        end
    end

    assign r_x       = res6_reg[0];
    assign r_y       = res6_reg[1];
    assign r_z       = res6_reg[2];
    assign r_w       = res6_reg[3];
    assign saturated = clip6_reg;

endmodule
